FILE: hdl/vrq_pkg.sv
`timescale 1ns / 1ps
package vrq_pkg;

  localparam int RING_BYTES_DEF   = 1024;
  localparam int HEADER_BYTES_DEF = 4;
  localparam int MAX_READ_DEF     = 64;

  localparam int ACTION_W = 3;
  localparam int COUNT_W  = 10;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int FREEO_W  = 11;
  localparam int STEP_W   = 7;

  localparam logic [ACTION_W-1:0] ACT_PUSH_START = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BYTE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP        = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PEEK       = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SEQ     = 2'd3;

  typedef enum logic [2:0] {
    OP_START,
    OP_BYTE,
    OP_POP,
    OP_PEEK,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [COUNT_W-1:0] count;
    logic [BYTE_W-1:0]  data;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR_WR,
    S_HDR_RD,
    S_LEN,
    S_DATA,
    S_FINAL
  } state_t;

endpackage

FILE: hdl/vrq_if.sv
`timescale 1ns / 1ps
interface vrq_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [9:0] byte_count;
  logic [7:0] data_byte;

  modport source (output valid, action, byte_count, data_byte, input ready);
  modport sink (input valid, action, byte_count, data_byte, output ready);
endinterface

interface vrq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [10:0] free_bytes;
  logic        is_empty;

  modport source (output valid, status, out_byte, byte_valid, last, free_bytes, is_empty,
                  input ready);
  modport sink (input valid, status, out_byte, byte_valid, last, free_bytes, is_empty,
                output ready);
endinterface

FILE: hdl/variable_record_ring_queue.sv
`timescale 1ns / 1ps
// Byte ring queue of length-prefixed records. Items enter a two-beat command
// queue and are carried out one at a time by a sequencer around a byte ring
// with one write and one read port and registered read data. Clear,
// push_byte, refused and unknown items are answered from idle; an accepted
// push_start writes one header byte per cycle, then gives the result beat.
// Pop and peek fetch the header, then each delivered byte, with an address
// and a data phase per byte, set by the registered read data of the ring, or
// give a single result beat when no byte is delivered. Output stalls hold the
// sequencer where it emits a beat; the command queue keeps taking beats until
// its two slots are full. No clearing pass after reset.
module variable_record_ring_queue import vrq_pkg::*; #(
  parameter int RING_BYTES   = RING_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_READ     = MAX_READ_DEF
) (
  input  logic      clk,
  input  logic      rst,
  vrq_in_if.sink    in,
  vrq_out_if.source out
);

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic bk_valid, bk_ready;
  cmd_t bk_cmd;

  vrq_front u_front (
    .in        (in),
    .cmd_valid (fr_valid),
    .cmd       (fr_cmd),
    .cmd_ready (fr_ready)
  );

  vrq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_cmd   (fr_cmd),
    .wr_ready (fr_ready),
    .rd_valid (bk_valid),
    .rd_cmd   (bk_cmd),
    .rd_ready (bk_ready)
  );

  vrq_back #(
    .RING_BYTES   (RING_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_READ     (MAX_READ)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (bk_valid),
    .cmd       (bk_cmd),
    .cmd_ready (bk_ready),
    .out       (out)
  );

endmodule

FILE: hdl/vrq_front.sv
`timescale 1ns / 1ps
module vrq_front import vrq_pkg::*; (
  vrq_in_if.sink     in,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_ready
);

  always_comb begin
    case (in.action)
      ACT_PUSH_START: cmd.op = OP_START;
      ACT_PUSH_BYTE:  cmd.op = OP_BYTE;
      ACT_POP:        cmd.op = OP_POP;
      ACT_PEEK:       cmd.op = OP_PEEK;
      ACT_CLEAR:      cmd.op = OP_CLEAR;
      default:        cmd.op = OP_NOP;
    endcase
    cmd.count = in.byte_count;
    cmd.data  = in.data_byte;
  end

  assign cmd_valid = in.valid;
  assign in.ready  = cmd_ready;

endmodule

FILE: hdl/vrq_queue.sv
`timescale 1ns / 1ps
module vrq_queue import vrq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  input  cmd_t wr_cmd,
  output logic wr_ready,
  output logic rd_valid,
  output cmd_t rd_cmd,
  input  logic rd_ready
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pull;

  assign wr_ready = fill != 2'd2;
  assign rd_valid = fill != 2'd0;
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pull     = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pull) rd_ptr <= !rd_ptr;
      if (push && !pull) fill <= fill + 2'd1;
      else if (pull && !push) fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_cmd;
  end

endmodule

FILE: hdl/vrq_back.sv
`timescale 1ns / 1ps
module vrq_back import vrq_pkg::*; #(
  parameter int RING_BYTES   = RING_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_READ     = MAX_READ_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   cmd_valid,
  input  cmd_t   cmd,
  output logic   cmd_ready,
  vrq_out_if.source out
);

  localparam int POS_W  = $clog2(RING_BYTES);
  localparam int FREE_W = $clog2(RING_BYTES + 1);
  localparam int CMP_W  = (FREE_W > FREEO_W ? FREE_W : FREEO_W) + 1;
  localparam int ADV_W  = (POS_W > COUNT_W ? POS_W : COUNT_W) + 1;
  localparam int HDR_BITS = 8 * HEADER_BYTES;
  localparam logic [POS_W-1:0]  LAST_POS = POS_W'(RING_BYTES - 1);
  localparam logic [FREE_W-1:0] FULL_FREE = FREE_W'(RING_BYTES);
  localparam logic [STEP_W-1:0] HDR_LAST = STEP_W'(HEADER_BYTES - 1);

  logic [BYTE_W-1:0] ring [RING_BYTES];
  logic [BYTE_W-1:0] rd_data;

  state_t state, state_next;
  logic [POS_W-1:0]   rd_pos, rd_pos_next;
  logic [POS_W-1:0]   wr_pos, wr_pos_next;
  logic [POS_W-1:0]   cur_pos, cur_pos_next;
  logic [FREE_W-1:0]  free_cnt, free_next;
  logic [COUNT_W-1:0] push_rem, push_rem_next;
  logic [COUNT_W-1:0] len, len_next;
  logic [COUNT_W-1:0] req, req_next;
  logic [STEP_W-1:0]  take, take_next;
  logic [STEP_W-1:0]  step, step_next;
  logic               phase, phase_next;
  logic               is_pop, is_pop_next;
  logic [STATUS_W-1:0] fin_status, fin_status_next;

  logic                slot_free;
  logic                emit;
  logic [STATUS_W-1:0] e_status;
  logic [BYTE_W-1:0]   e_byte;
  logic                e_valid;
  logic                e_last;
  logic                mem_we;
  logic [BYTE_W-1:0]   mem_wdata;

  logic                fits;
  logic                room;
  logic [CMP_W-1:0]    need;
  logic [CMP_W-1:0]    freed;
  logic [ADV_W-1:0]    adv;
  logic [COUNT_W-1:0]  cap;
  logic                data_last;

  function automatic logic [POS_W-1:0] inc_pos(input logic [POS_W-1:0] p);
    return (p == LAST_POS) ? '0 : p + POS_W'(1);
  endfunction

  assign slot_free = !out.valid || out.ready;
  assign fits = (HDR_BITS >= COUNT_W) ? 1'b1 : ((cmd.count >> HDR_BITS) == '0);
  assign need = CMP_W'(HEADER_BYTES) + CMP_W'(cmd.count);
  assign room = CMP_W'(free_cnt) >= need;
  assign freed = CMP_W'(free_cnt) + CMP_W'(HEADER_BYTES) + CMP_W'(len);
  assign adv = ADV_W'(cur_pos) + ADV_W'(len);
  assign data_last = step == take - STEP_W'(1);

  // take = min(len, requested, MAX_READ)
  always_comb begin
    cap = (len < req) ? len : req;
    if (cap > COUNT_W'(MAX_READ)) cap = COUNT_W'(MAX_READ);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          if (push_rem == '0 && cmd.op == OP_START && fits && room) state_next = S_HDR_WR;
          else if (push_rem == '0 && (cmd.op == OP_POP || cmd.op == OP_PEEK) &&
                   free_cnt != FULL_FREE) state_next = S_HDR_RD;
        end
      end
      S_HDR_WR: if (step == HDR_LAST) state_next = S_FINAL;
      S_HDR_RD: if (phase && step == HDR_LAST) state_next = S_LEN;
      S_LEN:    state_next = (cap == '0) ? S_FINAL : S_DATA;
      S_DATA:   if (phase && slot_free && data_last) state_next = S_IDLE;
      S_FINAL:  if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_pos_next     = rd_pos;
    wr_pos_next     = wr_pos;
    cur_pos_next    = cur_pos;
    free_next       = free_cnt;
    push_rem_next   = push_rem;
    len_next        = len;
    req_next        = req;
    take_next       = take;
    step_next       = step;
    phase_next      = phase;
    is_pop_next     = is_pop;
    fin_status_next = fin_status;
    cmd_ready = 1'b0;
    emit      = 1'b0;
    e_status  = ST_OK;
    e_byte    = '0;
    e_valid   = 1'b0;
    e_last    = 1'b1;
    mem_we    = 1'b0;
    mem_wdata = cmd.data;
    case (state)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_ready = 1'b1;
          case (cmd.op)
            OP_CLEAR: begin
              rd_pos_next   = wr_pos;
              free_next     = FULL_FREE;
              push_rem_next = '0;
              emit = 1'b1;
            end
            OP_BYTE: begin
              emit = 1'b1;
              if (push_rem == '0) begin
                e_status = ST_SEQ;
              end else begin
                mem_we        = 1'b1;
                wr_pos_next   = inc_pos(wr_pos);
                push_rem_next = push_rem - COUNT_W'(1);
              end
            end
            OP_START: begin
              if (push_rem != '0) begin
                emit = 1'b1;
                e_status = ST_SEQ;
              end else if (!fits || !room) begin
                emit = 1'b1;
                e_status = ST_NO_ROOM;
              end else begin
                free_next     = FREE_W'(CMP_W'(free_cnt) - need);
                push_rem_next = cmd.count;
                len_next      = cmd.count;
                step_next     = '0;
              end
            end
            OP_POP, OP_PEEK: begin
              if (push_rem != '0) begin
                emit = 1'b1;
                e_status = ST_SEQ;
              end else if (free_cnt == FULL_FREE) begin
                emit = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                cur_pos_next = rd_pos;
                len_next     = '0;
                req_next     = cmd.count;
                is_pop_next  = cmd.op == OP_POP;
                step_next    = '0;
                phase_next   = 1'b0;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_HDR_WR: begin
        mem_we      = 1'b1;
        mem_wdata   = BYTE_W'(len >> {step, 3'b000});
        wr_pos_next = inc_pos(wr_pos);
        step_next   = step + STEP_W'(1);
        fin_status_next = ST_OK;
      end
      S_HDR_RD: begin
        // read data is registered, so it lags the address; phase marks when it is valid
        phase_next = !phase;
        if (phase) begin
          if (step == STEP_W'(0)) len_next[7:0] = rd_data;
          else if (step == STEP_W'(1)) len_next[COUNT_W-1:8] = rd_data[COUNT_W-9:0];
          cur_pos_next = inc_pos(cur_pos);
          step_next    = step + STEP_W'(1);
        end
      end
      S_LEN: begin
        take_next  = STEP_W'(cap);
        step_next  = '0;
        phase_next = 1'b0;
        fin_status_next = ST_OK;
        if (is_pop) begin
          free_next   = (freed > CMP_W'(RING_BYTES)) ? FULL_FREE : FREE_W'(freed);
          rd_pos_next = (adv >= ADV_W'(RING_BYTES)) ? POS_W'(adv - ADV_W'(RING_BYTES))
                                                    : POS_W'(adv);
        end
      end
      S_DATA: begin
        if (!phase) begin
          phase_next = 1'b1;
        end else if (slot_free) begin
          emit    = 1'b1;
          e_byte  = rd_data;
          e_valid = 1'b1;
          e_last  = data_last;
          cur_pos_next = inc_pos(cur_pos);
          step_next    = step + STEP_W'(1);
          phase_next   = 1'b0;
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          emit     = 1'b1;
          e_status = fin_status;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pos     <= '0;
      wr_pos     <= '0;
      cur_pos    <= '0;
      free_cnt   <= FULL_FREE;
      push_rem   <= '0;
      step       <= '0;
      take       <= '0;
      phase      <= 1'b0;
      is_pop     <= 1'b0;
      fin_status <= ST_OK;
      out.valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pos     <= rd_pos_next;
      wr_pos     <= wr_pos_next;
      cur_pos    <= cur_pos_next;
      free_cnt   <= free_next;
      push_rem   <= push_rem_next;
      step       <= step_next;
      take       <= take_next;
      phase      <= phase_next;
      is_pop     <= is_pop_next;
      fin_status <= fin_status_next;
      if (emit) out.valid <= 1'b1;
      else if (out.ready) out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    len <= len_next;
    req <= req_next;
    if (emit) begin
      out.status     <= e_status;
      out.out_byte   <= e_byte;
      out.byte_valid <= e_valid;
      out.last       <= e_last;
      out.free_bytes <= FREEO_W'(free_next);
      out.is_empty   <= free_next == FULL_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring[wr_pos] <= mem_wdata;
    rd_data <= ring[cur_pos];
  end

endmodule
